/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* hw/rtl/psb_pkg.sv */
// ----------------------------------------------------------------------------
// psb_pkg
// Widths and codes shared by the prime sieve bitmap modules.
// ----------------------------------------------------------------------------
package psb_pkg;

	localparam int NUM_W    = 17;
	localparam int NUM_MAX  = 131071;
	localparam int BASE_W   = 9;   // bases up to 363
	localparam int SQ_W     = 18;  // base squared and running multiple
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] ST_BUILT = 2'd0;
	localparam logic [STATUS_W-1:0] ST_PRIME = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	localparam logic FUNC_BUILD = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [NUM_W-1:0] RESET_LIMIT = 17'd100000;

endpackage

/* hw/rtl/psb_ram.sv */
// ----------------------------------------------------------------------------
// psb_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module psb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                         wdata,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

/* hw/rtl/psb_wdiv.sv */
// ----------------------------------------------------------------------------
// psb_wdiv
// Splits a number into map word index and bit offset, two-stage pipeline.
// ----------------------------------------------------------------------------
module psb_wdiv #(
	parameter int WORD_BITS = 32,
	parameter int ADDR_W    = 12
) (
	input  logic                         clk,
	input  logic [psb_pkg::NUM_W-1:0]    n,
	output logic [ADDR_W-1:0]            word,
	output logic [$clog2(WORD_BITS)-1:0] bit_idx
);

	localparam int NW    = psb_pkg::NUM_W;
	localparam int BIT_W = $clog2(WORD_BITS);
	// shift wide enough that the rounded-up reciprocal gives an exact quotient
	localparam int SH    = NW + BIT_W + 1;
	localparam int PW    = SH + NW;
	localparam longint unsigned RECIP = ((64'd1 << SH) + WORD_BITS - 1) / WORD_BITS;

	logic [PW-1:0] prod;
	logic [NW-1:0] qw;
	logic [NW-1:0] q_s1;
	logic [NW-1:0] n_s1;

	assign prod = PW'(n) * PW'(RECIP);
	assign qw   = q_s1 * NW'(WORD_BITS);

	always_ff @(posedge clk) begin
		q_s1    <= prod[SH +: NW];
		n_s1    <= n;
		word    <= q_s1[ADDR_W-1:0];
		// remainder is below WORD_BITS, so low bits suffice
		bit_idx <= n_s1[BIT_W-1:0] - qw[BIT_W-1:0];
	end

endmodule

/* hw/rtl/prime_sieve_bitmap_unit.sv */
// ----------------------------------------------------------------------------
// prime_sieve_bitmap_unit
// Bitmap sieve of Eratosthenes with build and primality query.
// ----------------------------------------------------------------------------
//  channel | handshake            | word
//  in      | in_valid / in_ready  | func, number
//  out     | out_valid / out_ready| status, is_prime
//  cfg     | cfg_valid / cfg_ready| sieve_limit
//
//  Query: split (S_DIV), read (S_READ), test (S_TEST), output (S_DONE); a number
//  above the limit goes straight to S_DONE. Build: the map is cleared word by
//  word, then each base is tested by a read and each multiple marked by a
//  read-modify-write through the one RAM port. Reset: a clearing pass over all
//  MAP_WORDS words (4096 by default) runs first; in_ready stays low during it,
//  cfg writes are taken. A pending result in the output register stalls only the next result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prime_sieve_bitmap_unit #(
	parameter int MAX_NUMBERS = 131072,
	parameter int WORD_BITS   = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             func,
	input  logic [psb_pkg::NUM_W-1:0]        number,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [psb_pkg::STATUS_W-1:0]     status,
	output logic                             is_prime,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [psb_pkg::NUM_W-1:0]        sieve_limit
);

	localparam int NW        = psb_pkg::NUM_W;
	localparam int SW        = psb_pkg::SQ_W;
	localparam int BW        = psb_pkg::BASE_W;
	localparam int MAP_WORDS = (MAX_NUMBERS + WORD_BITS - 1) / WORD_BITS;
	localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam logic [NW-1:0] LIM_CAP = (MAX_NUMBERS - 1 > psb_pkg::NUM_MAX) ?
		NW'(psb_pkg::NUM_MAX) : NW'(MAX_NUMBERS - 1);
	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MAP_WORDS - 1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_TEST  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	localparam logic [1:0] MODE_QUERY = 2'd0;
	localparam logic [1:0] MODE_BASE  = 2'd1;
	localparam logic [1:0] MODE_MARK  = 2'd2;

	logic [2:0]                      state_q;
	logic [1:0]                      mode_q;
	logic                            build_q;
	logic                            wait_q;
	logic [ADDR_W-1:0]               clr_q;
	logic [NW-1:0]                   limit_q;
	logic [SW-1:0]                   n_q;
	logic [BW-1:0]                   base_q;
	logic [SW-1:0]                   sq_q;
	logic [psb_pkg::STATUS_W-1:0]    res_status_q;
	logic                            res_prime_q;
	logic                            out_valid_q;
	logic [psb_pkg::STATUS_W-1:0]    status_q;
	logic                            prime_q;

	logic [NW-1:0]          lim;
	logic [SW-1:0]          lim_x;
	logic [SW-1:0]          m_next;
	logic [SW-1:0]          sq_next;
	logic [BW-1:0]          base_next;
	logic [ADDR_W-1:0]      word;
	logic [BIT_W-1:0]       bit_idx;
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_addr;
	logic [WORD_BITS-1:0]   ram_wdata;
	logic [WORD_BITS-1:0]   ram_rdata;
	logic                   map_bit;

	assign lim       = (limit_q > LIM_CAP) ? LIM_CAP : limit_q;
	assign lim_x     = SW'(lim);
	assign m_next    = n_q + SW'(base_q);
	// (b+1)^2 = b^2 + 2b + 1
	assign sq_next   = sq_q + SW'({base_q, 1'b1});
	assign base_next = base_q + BW'(1);
	assign map_bit   = ram_rdata[bit_idx];

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign is_prime  = prime_q;

	psb_wdiv #(
		.WORD_BITS(WORD_BITS),
		.ADDR_W   (ADDR_W)
	) u_wdiv (
		.clk    (clk),
		.n      (n_q[NW-1:0]),
		.word   (word),
		.bit_idx(bit_idx)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = word;
		ram_wdata = ram_rdata | (WORD_BITS'(1) << bit_idx);
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_addr  = clr_q;
			ram_wdata = '0;
		end else if (state_q == S_TEST && mode_q == MODE_MARK) begin
			ram_we = 1'b1;
		end
	end

	psb_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			mode_q       <= MODE_QUERY;
			build_q      <= 1'b0;
			wait_q       <= 1'b0;
			clr_q        <= '0;
			limit_q      <= psb_pkg::RESET_LIMIT;
			n_q          <= '0;
			base_q       <= '0;
			sq_q         <= '0;
			res_status_q <= psb_pkg::ST_BUILT;
			res_prime_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			status_q     <= psb_pkg::ST_BUILT;
			prime_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				limit_q <= sieve_limit;
			end
			// S_DONE reloads the output register itself
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (clr_q == CLR_LAST) begin
						clr_q <= '0;
						if (build_q) begin
							base_q <= BW'(2);
							sq_q   <= SW'(4);
							if (SW'(4) > lim_x) begin
								build_q      <= 1'b0;
								res_status_q <= psb_pkg::ST_BUILT;
								res_prime_q  <= 1'b0;
								state_q      <= S_DONE;
							end else begin
								n_q     <= SW'(2);
								mode_q  <= MODE_BASE;
								wait_q  <= 1'b0;
								state_q <= S_DIV;
							end
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						clr_q <= clr_q + ADDR_W'(1);
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						if (func == psb_pkg::FUNC_BUILD) begin
							build_q <= 1'b1;
							clr_q   <= '0;
							state_q <= S_CLEAR;
						end else if (number > lim) begin
							res_status_q <= psb_pkg::ST_RANGE;
							res_prime_q  <= 1'b0;
							state_q      <= S_DONE;
						end else begin
							n_q     <= SW'(number);
							mode_q  <= MODE_QUERY;
							wait_q  <= 1'b0;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					// hold n_q steady until both split stages have it
					wait_q <= ~wait_q;
					if (wait_q) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_TEST;
				end
				S_TEST: begin
					unique case (mode_q)
						MODE_QUERY: begin
							res_status_q <= psb_pkg::ST_PRIME;
							res_prime_q  <= (n_q >= SW'(2)) && !map_bit;
							state_q      <= S_DONE;
						end
						MODE_BASE, MODE_MARK: begin
							if (mode_q == MODE_BASE && !map_bit) begin
								// unmarked base: start marking at its square
								n_q     <= sq_q;
								mode_q  <= MODE_MARK;
								wait_q  <= 1'b0;
								state_q <= S_DIV;
							end else if (mode_q == MODE_MARK && m_next <= lim_x) begin
								n_q     <= m_next;
								wait_q  <= 1'b0;
								state_q <= S_DIV;
							end else begin
								// advance to the next base
								base_q <= base_next;
								sq_q   <= sq_next;
								if (sq_next > lim_x) begin
									build_q      <= 1'b0;
									res_status_q <= psb_pkg::ST_BUILT;
									res_prime_q  <= 1'b0;
									state_q      <= S_DONE;
								end else begin
									n_q     <= SW'(base_next);
									mode_q  <= MODE_BASE;
									wait_q  <= 1'b0;
									state_q <= S_DIV;
								end
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						prime_q     <= res_prime_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`ASSERT_IMPL(a_mark_in_range, state_q == S_DIV && mode_q == MODE_MARK,
		n_q <= lim_x && n_q >= SW'(4))
	`ASSERT_IMPL(a_base_tracks, state_q == S_DIV && mode_q == MODE_BASE,
		n_q == SW'(base_q) && sq_q <= lim_x)
	`ASSERT_IMPL(a_build_not_prime, out_valid && status == psb_pkg::ST_BUILT, !is_prime)

endmodule

/* tb/prime_sieve_bitmap_unit_tb.sv */
// ----------------------------------------------------------------------------
// prime_sieve_bitmap_unit_tb
// Drives build and query words into the sieve and compares every answer with
// a bit-exact predictor of the composite map. The limit register is rewritten
// between phases while the unit is idle. Both sides idle at random, and one
// phase holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------
module prime_sieve_bitmap_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAP_BITS   = 131072;
	localparam int HOLD_SPAN  = 500;

	typedef struct packed {
		logic                      func;
		logic [psb_pkg::NUM_W-1:0] number;
	} sieve_request_t;

	typedef struct packed {
		logic [psb_pkg::STATUS_W-1:0] status;
		logic                         is_prime;
	} sieve_answer_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic                         func;
	logic [psb_pkg::NUM_W-1:0]    number;
	logic                         out_valid;
	logic                         out_ready;
	logic [psb_pkg::STATUS_W-1:0] status;
	logic                         is_prime;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [psb_pkg::NUM_W-1:0]    sieve_limit;

	sieve_request_t pending_requests[$];
	sieve_answer_t  answers_due[$];
	bit             composite_bits [MAP_BITS];
	int             limit_now;
	int             requests_queued;
	int             requests_taken;
	int             errors;
	int             send_gap;
	int             send_gap_pct;
	int             stall_left;
	int             stall_pct;
	int             hold_left;
	logic           hold_arm;

	prime_sieve_bitmap_unit #(
		.MAX_NUMBERS(MAP_BITS),
		.WORD_BITS(32)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.number(number),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.is_prime(is_prime),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.sieve_limit(sieve_limit)
	);

	always #6 clk = ~clk;

	// mostly no gap, some short ones, a few long ones
	function automatic int pick_gap(input int pct);
		int roll;
		roll = $urandom_range(99);
		if (roll >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(60, 20);
		return $urandom_range(3, 1);
	endfunction

	function automatic void sieve_rebuild();
		int top;
		int base;
		int mult;
		top = limit_now;
		if (top > MAP_BITS - 1)
			top = MAP_BITS - 1;
		foreach (composite_bits[i])
			composite_bits[i] = 1'b0;
		for (base = 2; base * base <= top; base++) begin
			if (!composite_bits[base]) begin
				for (mult = base * base; mult <= top; mult += base)
					composite_bits[mult] = 1'b1;
			end
		end
	endfunction

	function automatic sieve_answer_t sieve_predict(input sieve_request_t req);
		sieve_answer_t ans;
		int top;
		top = limit_now;
		if (top > MAP_BITS - 1)
			top = MAP_BITS - 1;
		ans.is_prime = 1'b0;
		if (req.func == psb_pkg::FUNC_BUILD) begin
			sieve_rebuild();
			ans.status = psb_pkg::ST_BUILT;
		end else if (int'(req.number) > top) begin
			ans.status = psb_pkg::ST_RANGE;
		end else begin
			// map is read as it stands, whatever limit it was built with
			ans.status   = psb_pkg::ST_PRIME;
			ans.is_prime = (req.number >= 2) && !composite_bits[req.number];
		end
		return ans;
	endfunction

	// sender: one word in flight, predicted on acceptance
	always @(posedge clk) begin : drive_requests
		sieve_request_t req;
		logic           offer;
		if (arst_n) begin
			offer = in_valid;
			if (in_valid && in_ready) begin
				answers_due.push_back(sieve_predict('{func: func, number: number}));
				requests_taken++;
				offer = 1'b0;
			end
			if (!offer) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_requests.size() != 0) begin
					req = pending_requests.pop_front();
					func   <= req.func;
					number <= req.number;
					offer = 1'b1;
					send_gap = pick_gap(send_gap_pct);
				end
			end
			in_valid <= offer;
		end
	end

	// long receiver hold-off, counted here so the monitor only reads it
	always @(posedge clk) begin
		if (hold_arm) begin
			hold_left <= HOLD_SPAN;
			hold_arm  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin : check_answers
		sieve_answer_t due;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					$display("%0t: word with nothing expected, status=%0d is_prime=%0b",
						$time, status, is_prime);
					errors++;
				end else begin
					due = answers_due.pop_front();
					if (status !== due.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, due.status, status);
						errors++;
					end
					if (is_prime !== due.is_prime) begin
						$display("%0t: is_prime expected %0b actual %0b",
							$time, due.is_prime, is_prime);
						errors++;
					end
				end
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				stall_left = pick_gap(stall_pct);
			end
		end
	end

	task automatic add_request(input logic f, input int n);
		pending_requests.push_back('{func: f, number: n[psb_pkg::NUM_W-1:0]});
		requests_queued++;
	endtask

	task automatic wait_drained();
		while (requests_taken != requests_queued || answers_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_limit(input int value);
		@(posedge clk);
		sieve_limit <= value[psb_pkg::NUM_W-1:0];
		cfg_valid   <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_now = value & psb_pkg::NUM_MAX;
	endtask

	function automatic int pick_number(input int lim);
		int roll;
		int n;
		roll = $urandom_range(99);
		if (roll < 55) begin
			n = $urandom_range(lim);
		end else if (roll < 70) begin
			n = lim + $urandom_range(4) - 2;
			if (n < 0)
				n = 0;
			if (n > psb_pkg::NUM_MAX)
				n = psb_pkg::NUM_MAX;
		end else if (roll < 80) begin
			n = $urandom_range(3);
		end else begin
			n = $urandom_range(psb_pkg::NUM_MAX);
		end
		return n;
	endfunction

	initial begin
		int phase;
		int roll;
		int lim;
		int count;
		int k;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		func         = psb_pkg::FUNC_QUERY;
		number       = '0;
		out_ready    = 1'b0;
		cfg_valid    = 1'b0;
		sieve_limit  = psb_pkg::RESET_LIMIT;
		hold_arm     = 1'b0;
		hold_left    = 0;
		limit_now    = psb_pkg::RESET_LIMIT;
		send_gap_pct = 10;
		stall_pct    = 10;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset limit, empty map: everything from two up to the limit reads prime
		add_request(psb_pkg::FUNC_QUERY, 0);
		add_request(psb_pkg::FUNC_QUERY, 1);
		add_request(psb_pkg::FUNC_QUERY, 2);
		add_request(psb_pkg::FUNC_QUERY, 4);
		add_request(psb_pkg::FUNC_QUERY, 100000);
		add_request(psb_pkg::FUNC_QUERY, 100001);
		add_request(psb_pkg::FUNC_QUERY, psb_pkg::NUM_MAX);
		wait_drained();

		// smallest useful limit
		write_limit(2);
		add_request(psb_pkg::FUNC_BUILD, psb_pkg::NUM_MAX);
		add_request(psb_pkg::FUNC_QUERY, 0);
		add_request(psb_pkg::FUNC_QUERY, 1);
		add_request(psb_pkg::FUNC_QUERY, 2);
		add_request(psb_pkg::FUNC_QUERY, 3);
		wait_drained();

		// limit below two: build marks nothing
		write_limit(1);
		add_request(psb_pkg::FUNC_BUILD, 0);
		add_request(psb_pkg::FUNC_QUERY, 0);
		add_request(psb_pkg::FUNC_QUERY, 1);
		add_request(psb_pkg::FUNC_QUERY, 2);
		wait_drained();

		write_limit(1000);
		add_request(psb_pkg::FUNC_BUILD, 0);
		add_request(psb_pkg::FUNC_QUERY, 997);
		add_request(psb_pkg::FUNC_QUERY, 961);
		add_request(psb_pkg::FUNC_QUERY, 1000);
		add_request(psb_pkg::FUNC_QUERY, 1001);
		wait_drained();

		// raise the limit without a rebuild: stale map above the old limit
		write_limit(psb_pkg::NUM_MAX);
		add_request(psb_pkg::FUNC_QUERY, 999);
		add_request(psb_pkg::FUNC_QUERY, 5000);
		add_request(psb_pkg::FUNC_QUERY, psb_pkg::NUM_MAX);
		wait_drained();

		for (phase = 0; phase < 16; phase++) begin
			roll = $urandom_range(9);
			if (roll == 0)
				lim = $urandom_range(1);
			else if (roll < 5)
				lim = $urandom_range(300, 2);
			else if (roll < 8)
				lim = $urandom_range(3000, 301);
			else
				lim = $urandom_range(psb_pkg::NUM_MAX, 30000);
			roll = $urandom_range(2);
			send_gap_pct = (roll == 0) ? 0 : (roll == 1) ? 10 : 40;
			roll = $urandom_range(2);
			stall_pct = (roll == 0) ? 0 : (roll == 1) ? 10 : 40;
			write_limit(lim);
			// large limits are query only so the run stays short
			if (lim <= 3000)
				add_request(psb_pkg::FUNC_BUILD, $urandom_range(psb_pkg::NUM_MAX));
			count = $urandom_range(120, 90);
			for (k = 0; k < count; k++) begin
				if (lim <= 3000 && $urandom_range(49) == 0)
					add_request(psb_pkg::FUNC_BUILD, $urandom_range(psb_pkg::NUM_MAX));
				else
					add_request(psb_pkg::FUNC_QUERY, pick_number(lim));
			end
			wait_drained();
		end

		// one mid-size build, receiver always ready
		send_gap_pct = 10;
		stall_pct    = 0;
		write_limit(20000);
		add_request(psb_pkg::FUNC_BUILD, 0);
		for (k = 0; k < 100; k++)
			add_request(psb_pkg::FUNC_QUERY, pick_number(20000));
		wait_drained();

		// back-pressure: hold the output off while queries keep coming
		send_gap_pct = 0;
		stall_pct    = 10;
		@(posedge clk);
		hold_arm <= 1'b1;
		for (k = 0; k < 120; k++)
			add_request(psb_pkg::FUNC_QUERY, pick_number(20000));
		wait_drained();

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("[prime_sieve_bitmap_unit] OK");
		else
			$display("[prime_sieve_bitmap_unit] ERROR");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("[prime_sieve_bitmap_unit] ERROR");
		$finish;
	end

endmodule
